// ===== rtl/etm_pkg.sv =====
// Shared types, constants and saturating fixed-point helpers for the edge momentum tendency block.
package etm_pkg;

    localparam int DATA_WIDTH  = 48;
    localparam int FRAC_BITS   = 16;
    localparam int FIELD_WIDTH = 48;
    localparam int WIDE_WIDTH  = 65;
    localparam int HALF_WIDTH  = (DATA_WIDTH + 1) / 2;
    localparam int PROD_WIDTH  = 2 * DATA_WIDTH;
    localparam int FIFO_DEPTH  = 2;
    localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

    typedef logic signed [DATA_WIDTH-1:0]  data_t;
    typedef logic signed [FIELD_WIDTH-1:0] field_t;
    typedef logic signed [WIDE_WIDTH-1:0]  wide_t;

    localparam data_t DATA_MAX  = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam data_t DATA_MIN  = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam data_t DATA_ZERO = '0;

    typedef enum logic [2:0] {
        KIND_MIDDLE   = 3'd0,
        KIND_FIRST    = 3'd1,
        KIND_LAST     = 3'd2,
        KIND_ONLY     = 3'd3,
        KIND_NO_NBR   = 3'd4,
        KIND_BOUNDARY = 3'd5
    } kind_t;

    // Decoded item handed from the front end to the sequencer
    typedef struct packed {
        logic  has_term;
        logic  restart;
        logic  emit;
        logic  boundary;
        data_t weight;
        data_t u_nbr;
        data_t pv_half;
        data_t neg_moist;
        data_t dp;
        data_t dk;
        data_t inv_dist;
        data_t rho;
    } cmd_t;

    function automatic data_t sat_wide(wide_t x);
        if (x > WIDE_WIDTH'(DATA_MAX)) begin
            return DATA_MAX;
        end
        else if (x < WIDE_WIDTH'(DATA_MIN)) begin
            return DATA_MIN;
        end
        else begin
            return DATA_WIDTH'(x);
        end
    endfunction

    function automatic data_t from_field(field_t v);
        return sat_wide(WIDE_WIDTH'(v));
    endfunction

    function automatic field_t to_field(data_t v);
        return FIELD_WIDTH'(v);
    endfunction

    function automatic data_t sat_add(data_t a, data_t b);
        return sat_wide(WIDE_WIDTH'(a) + WIDE_WIDTH'(b));
    endfunction

    function automatic data_t sat_sub(data_t a, data_t b);
        return sat_wide(WIDE_WIDTH'(a) - WIDE_WIDTH'(b));
    endfunction

    // floor((a+b)/2); always in range
    function automatic data_t half_of(data_t a, data_t b);
        wide_t s;
        s = (WIDE_WIDTH'(a) + WIDE_WIDTH'(b)) >>> 1;
        return DATA_WIDTH'(s);
    endfunction

endpackage

// ===== rtl/etm_front.sv =====
// Input front end: accepts items, decodes the kind and forms the cheap operand differences.
module etm_front
    import etm_pkg::*;
(
    input  logic         in_valid,
    output logic         in_stall,
    input  logic [2:0]   kind,
    input  field_t       weight,
    input  field_t       u_nbr,
    input  field_t       pv_nbr,
    input  field_t       pv_self,
    input  field_t       pressure_cell0,
    input  field_t       pressure_cell1,
    input  field_t       ke_cell0,
    input  field_t       ke_cell1,
    input  field_t       moist_coef,
    input  field_t       inv_dist,
    input  field_t       rho,
    input  logic         q_full,
    output logic         q_push,
    output cmd_t         q_data
);

    logic known;

    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full && known;

    always_comb
    begin
        known            = 1'b1;
        q_data.has_term  = 1'b0;
        q_data.restart   = 1'b0;
        q_data.emit      = 1'b0;
        q_data.boundary  = 1'b0;
        unique case (kind_t'(kind))
            KIND_MIDDLE:
            begin
                q_data.has_term = 1'b1;
            end
            KIND_FIRST:
            begin
                q_data.has_term = 1'b1;
                q_data.restart  = 1'b1;
            end
            KIND_LAST:
            begin
                q_data.has_term = 1'b1;
                q_data.emit     = 1'b1;
            end
            KIND_ONLY:
            begin
                q_data.has_term = 1'b1;
                q_data.restart  = 1'b1;
                q_data.emit     = 1'b1;
            end
            KIND_NO_NBR:
            begin
                q_data.emit = 1'b1;
            end
            KIND_BOUNDARY:
            begin
                q_data.boundary = 1'b1;
            end
            default:
            begin
                known = 1'b0;   // unused codes are taken and dropped
            end
        endcase

        q_data.weight    = from_field(weight);
        q_data.u_nbr     = from_field(u_nbr);
        q_data.pv_half   = half_of(from_field(pv_self), from_field(pv_nbr));
        q_data.neg_moist = sat_sub(DATA_ZERO, from_field(moist_coef));
        q_data.dp        = sat_sub(from_field(pressure_cell1), from_field(pressure_cell0));
        q_data.dk        = sat_sub(from_field(ke_cell1), from_field(ke_cell0));
        q_data.inv_dist  = from_field(inv_dist);
        q_data.rho       = from_field(rho);
    end

endmodule

// ===== rtl/etm_fifo.sv =====
// Short command queue between the front end and the sequencer.
module etm_fifo
    import etm_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  cmd_t  push_data,
    input  logic  pop,
    output cmd_t  pop_data,
    output logic  full,
    output logic  empty
);

    cmd_t                  mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0] count_reg, count_next;

    function automatic logic [FIFO_PTR_W-1:0] ptr_inc(logic [FIFO_PTR_W-1:0] p);
        if (p == FIFO_PTR_W'(FIFO_DEPTH - 1)) begin
            return '0;
        end
        else begin
            return p + 1'b1;
        end
    endfunction

    assign full     = (count_reg == FIFO_CNT_W'(FIFO_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop  ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/etm_mul.sv =====
// Shared multi-cycle fixed-point multiplier: half-width partial products, floor shift, saturation.
module etm_mul
    import etm_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  data_t a,
    input  data_t b,
    output logic  done,
    output data_t result
);

    typedef enum logic [3:0] {
        M_IDLE = 4'b0001,
        M_PP   = 4'b0010,
        M_NEG  = 4'b0100,
        M_SAT  = 4'b1000
    } mstate_t;

    mstate_t                     state_reg, state_next;
    logic [1:0]                  cnt_reg, cnt_next;
    logic                        done_reg, done_next;
    logic [DATA_WIDTH-1:0]       mag_a_reg, mag_a_next;
    logic [DATA_WIDTH-1:0]       mag_b_reg, mag_b_next;
    logic                        neg_reg, neg_next;
    logic [PROD_WIDTH-1:0]       acc_reg, acc_next;
    logic signed [PROD_WIDTH:0]  sp_reg, sp_next;
    data_t                       result_reg, result_next;

    logic [HALF_WIDTH-1:0]       op_x, op_y;
    logic [2*HALF_WIDTH-1:0]     pp;
    logic [PROD_WIDTH-1:0]       pp_ext, pp_sh;
    logic signed [PROD_WIDTH:0]  acc_ext, sh;
    logic [PROD_WIDTH-DATA_WIDTH+1:0] top;

    assign done   = done_reg;
    assign result = result_reg;

    always_comb
    begin
        // cnt bit 0 picks the high half of a, bit 1 the high half of b
        op_x   = cnt_reg[0] ? HALF_WIDTH'(mag_a_reg >> HALF_WIDTH) : mag_a_reg[HALF_WIDTH-1:0];
        op_y   = cnt_reg[1] ? HALF_WIDTH'(mag_b_reg >> HALF_WIDTH) : mag_b_reg[HALF_WIDTH-1:0];
        pp     = (2*HALF_WIDTH)'(op_x) * (2*HALF_WIDTH)'(op_y);
        pp_ext = PROD_WIDTH'(pp);
        case (cnt_reg)
            2'd0:    pp_sh = pp_ext;
            2'd1:    pp_sh = pp_ext << HALF_WIDTH;
            2'd2:    pp_sh = pp_ext << HALF_WIDTH;
            default: pp_sh = pp_ext << (2 * HALF_WIDTH);
        endcase

        acc_ext = $signed({1'b0, acc_reg});
        sh      = sp_reg >>> FRAC_BITS;
        top     = sh[PROD_WIDTH:DATA_WIDTH-1];

        state_next  = state_reg;
        cnt_next    = cnt_reg;
        done_next   = 1'b0;
        mag_a_next  = mag_a_reg;
        mag_b_next  = mag_b_reg;
        neg_next    = neg_reg;
        acc_next    = acc_reg;
        sp_next     = sp_reg;
        result_next = result_reg;

        unique case (state_reg)
            M_IDLE:
            begin
                if (start)
                begin
                    mag_a_next = a[DATA_WIDTH-1] ? $unsigned(-a) : $unsigned(a);
                    mag_b_next = b[DATA_WIDTH-1] ? $unsigned(-b) : $unsigned(b);
                    neg_next   = a[DATA_WIDTH-1] ^ b[DATA_WIDTH-1];
                    acc_next   = '0;
                    cnt_next   = '0;
                    state_next = M_PP;
                end
            end
            M_PP:
            begin
                acc_next = acc_reg + pp_sh;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 2'd3)
                begin
                    state_next = M_NEG;
                end
            end
            M_NEG:
            begin
                sp_next    = neg_reg ? -acc_ext : acc_ext;
                state_next = M_SAT;
            end
            M_SAT:
            begin
                // arithmetic shift floors toward minus infinity
                if ((&top) || !(|top))
                begin
                    result_next = DATA_WIDTH'(sh);
                end
                else
                begin
                    result_next = sh[PROD_WIDTH] ? DATA_MIN : DATA_MAX;
                end
                done_next  = 1'b1;
                state_next = M_IDLE;
            end
            default:
            begin
                state_next = M_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= M_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_a_reg  <= mag_a_next;
        mag_b_reg  <= mag_b_next;
        neg_reg    <= neg_next;
        acc_reg    <= acc_next;
        sp_reg     <= sp_next;
        result_reg <= result_next;
    end

endmodule

// ===== rtl/etm_back.sv =====
// Back end: sequences the multiplications of one item, keeps the running sum, holds the result.
module etm_back
    import etm_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   q_empty,
    output logic   q_pop,
    input  cmd_t   q_data,
    output logic   out_valid,
    input  logic   out_stall,
    output field_t tendency
);

    typedef enum logic [7:0] {
        B_IDLE = 8'b0000_0001,
        B_T1   = 8'b0000_0010,
        B_T2   = 8'b0000_0100,
        B_PG1  = 8'b0000_1000,
        B_PG2  = 8'b0001_0000,
        B_KG   = 8'b0010_0000,
        B_RHO  = 8'b0100_0000,
        B_OUT  = 8'b1000_0000
    } bstate_t;

    bstate_t state_reg, state_next;
    logic    issued_reg, issued_next;
    logic    out_valid_reg, out_valid_next;
    data_t   sum_reg, sum_next;
    cmd_t    cmd_reg, cmd_next;
    data_t   prod_reg, prod_next;
    data_t   pg_reg, pg_next;
    data_t   res_reg, res_next;
    field_t  tendency_reg, tendency_next;

    logic    is_mul;
    logic    mul_start;
    data_t   mul_a, mul_b;
    logic    mul_done;
    data_t   mul_res;
    logic    load;

    etm_mul u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mul_start),
        .a      (mul_a),
        .b      (mul_b),
        .done   (mul_done),
        .result (mul_res)
    );

    assign out_valid = out_valid_reg;
    assign tendency  = tendency_reg;
    assign q_pop     = (state_reg == B_IDLE) && !q_empty;
    assign mul_start = is_mul && !issued_reg;
    assign load      = (state_reg == B_OUT) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        is_mul = 1'b1;
        mul_a  = cmd_reg.weight;
        mul_b  = cmd_reg.u_nbr;
        unique case (state_reg)
            B_T1:
            begin
                mul_a = cmd_reg.weight;
                mul_b = cmd_reg.u_nbr;
            end
            B_T2:
            begin
                mul_a = prod_reg;
                mul_b = cmd_reg.pv_half;
            end
            B_PG1:
            begin
                mul_a = cmd_reg.neg_moist;
                mul_b = cmd_reg.dp;
            end
            B_PG2:
            begin
                mul_a = prod_reg;
                mul_b = cmd_reg.inv_dist;
            end
            B_KG:
            begin
                mul_a = cmd_reg.dk;
                mul_b = cmd_reg.inv_dist;
            end
            B_RHO:
            begin
                mul_a = cmd_reg.rho;
                mul_b = prod_reg;
            end
            default:
            begin
                is_mul = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        sum_next       = sum_reg;
        cmd_next       = cmd_reg;
        prod_next      = prod_reg;
        pg_next        = pg_reg;
        res_next       = res_reg;
        tendency_next  = load ? to_field(res_reg) : tendency_reg;
        out_valid_next = load ? 1'b1 : (out_valid_reg && out_stall);

        if (mul_done)
        begin
            issued_next = 1'b0;
        end
        else if (mul_start)
        begin
            issued_next = 1'b1;
        end
        else
        begin
            issued_next = issued_reg;
        end

        unique case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    cmd_next = q_data;
                    if (q_data.boundary)
                    begin
                        res_next   = DATA_ZERO;
                        sum_next   = DATA_ZERO;
                        state_next = B_OUT;
                    end
                    else if (q_data.has_term)
                    begin
                        state_next = B_T1;
                    end
                    else
                    begin
                        // edge without neighbours
                        sum_next   = DATA_ZERO;
                        state_next = B_PG1;
                    end
                end
            end
            B_T1:
            begin
                if (mul_done)
                begin
                    prod_next  = mul_res;
                    state_next = B_T2;
                end
            end
            B_T2:
            begin
                if (mul_done)
                begin
                    sum_next   = cmd_reg.restart ? mul_res : sat_add(sum_reg, mul_res);
                    state_next = cmd_reg.emit ? B_PG1 : B_IDLE;
                end
            end
            B_PG1:
            begin
                if (mul_done)
                begin
                    prod_next  = mul_res;
                    state_next = B_PG2;
                end
            end
            B_PG2:
            begin
                if (mul_done)
                begin
                    pg_next    = mul_res;
                    state_next = B_KG;
                end
            end
            B_KG:
            begin
                if (mul_done)
                begin
                    prod_next  = sat_sub(sum_reg, mul_res);
                    state_next = B_RHO;
                end
            end
            B_RHO:
            begin
                if (mul_done)
                begin
                    res_next   = sat_add(pg_reg, mul_res);
                    sum_next   = DATA_ZERO;
                    state_next = B_OUT;
                end
            end
            B_OUT:
            begin
                if (load)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            issued_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            sum_reg       <= DATA_ZERO;
        end
        else
        begin
            state_reg     <= state_next;
            issued_reg    <= issued_next;
            out_valid_reg <= out_valid_next;
            sum_reg       <= sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        prod_reg     <= prod_next;
        pg_reg       <= pg_next;
        res_reg      <= res_next;
        tendency_reg <= tendency_next;
    end

endmodule

// ===== rtl/edge_momentum_tendency.sv =====
// Top level of the edge momentum tendency block: front end, command queue and sequencer.
//
// Each first, middle, last or only item carries one neighbour-edge term of an edge's run; the
// item that closes the run (last, only, no-neighbour or boundary) returns one tendency, the
// others return nothing. All multiplications run through one shared multiplier that builds
// each product from four half-width partial products, one per cycle, then floors and
// saturates it. A two-entry queue lets the input side take items while the sequencer works
// and while a result waits.
module edge_momentum_tendency
    import etm_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_stall,
    input  logic [2:0]   kind,
    input  field_t       weight,
    input  field_t       u_nbr,
    input  field_t       pv_nbr,
    input  field_t       pv_self,
    input  field_t       pressure_cell0,
    input  field_t       pressure_cell1,
    input  field_t       ke_cell0,
    input  field_t       ke_cell1,
    input  field_t       moist_coef,
    input  field_t       inv_dist,
    input  field_t       rho,
    output logic         out_valid,
    input  logic         out_stall,
    output field_t       tendency
);

    logic q_full;
    logic q_empty;
    logic q_push;
    logic q_pop;
    cmd_t q_in;
    cmd_t q_out;

    etm_front u_front (
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .kind           (kind),
        .weight         (weight),
        .u_nbr          (u_nbr),
        .pv_nbr         (pv_nbr),
        .pv_self        (pv_self),
        .pressure_cell0 (pressure_cell0),
        .pressure_cell1 (pressure_cell1),
        .ke_cell0       (ke_cell0),
        .ke_cell1       (ke_cell1),
        .moist_coef     (moist_coef),
        .inv_dist       (inv_dist),
        .rho            (rho),
        .q_full         (q_full),
        .q_push         (q_push),
        .q_data         (q_in)
    );

    etm_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .pop_data  (q_out),
        .full      (q_full),
        .empty     (q_empty)
    );

    etm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .q_data    (q_out),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .tendency  (tendency)
    );

endmodule

// ===== rtl/etm_checker.sv =====
// Port-level checks for the edge momentum tendency block, bound to the top level.
module etm_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic signed [47:0] tendency
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(tendency))
        else $error("stalled result changed");

    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |-> !out_valid && !in_stall)
        else $error("handshake active in reset");

    // the queue only fills through an accepted item
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_stall) |-> $past(in_valid && !in_stall))
        else $error("input stall without an accepted item");

endmodule

bind edge_momentum_tendency etm_checker u_etm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .tendency  (tendency)
);

// ===== tb/etm_tendency_checker.sv =====
`timescale 1ns / 1ps
// Checker for the edge momentum tendency block: predicts each tendency and compares results.
module etm_tendency_checker
    import etm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_stall,
    input  logic [2:0] kind,
    input  field_t     weight,
    input  field_t     u_nbr,
    input  field_t     pv_nbr,
    input  field_t     pv_self,
    input  field_t     pressure_cell0,
    input  field_t     pressure_cell1,
    input  field_t     ke_cell0,
    input  field_t     ke_cell1,
    input  field_t     moist_coef,
    input  field_t     inv_dist,
    input  field_t     rho,
    input  logic       out_valid,
    input  logic       out_stall,
    input  field_t     tendency,
    output int         fail_count,
    output int         pending
);

    // wide enough for any exact product of two data words
    typedef logic signed [127:0] big_t;

    field_t tendency_q[$];
    data_t  coriolis_acc;
    field_t expected_tend;

    function automatic data_t clip(big_t x);
        big_t hi;
        big_t lo;
        hi = DATA_MAX;
        lo = DATA_MIN;
        if (x > hi)
            return DATA_MAX;
        if (x < lo)
            return DATA_MIN;
        return x[DATA_WIDTH-1:0];
    endfunction

    function automatic data_t widen(field_t v);
        big_t x;
        x = v;
        return clip(x);
    endfunction

    function automatic data_t fx_add(data_t a, data_t b);
        big_t x;
        big_t y;
        x = a;
        y = b;
        return clip(x + y);
    endfunction

    function automatic data_t fx_sub(data_t a, data_t b);
        big_t x;
        big_t y;
        x = a;
        y = b;
        return clip(x - y);
    endfunction

    // floor((a+b)/2)
    function automatic data_t fx_half(data_t a, data_t b);
        big_t x;
        big_t y;
        x = a;
        y = b;
        return clip((x + y) >>> 1);
    endfunction

    // exact product, floored by the fraction shift, then saturated
    function automatic data_t fx_mul(data_t a, data_t b);
        big_t x;
        big_t y;
        x = a;
        y = b;
        return clip((x * y) >>> FRAC_BITS);
    endfunction

    function automatic void absorb_item();
        data_t term;
        data_t pres_grad;
        data_t ke_grad;
        data_t result;
        if (kind == KIND_BOUNDARY)
        begin
            coriolis_acc = '0;
            tendency_q.push_back('0);
            return;
        end
        if (kind > KIND_BOUNDARY)
            return;
        term = fx_mul(fx_mul(widen(weight), widen(u_nbr)),
                      fx_half(widen(pv_self), widen(pv_nbr)));
        case (kind)
            KIND_FIRST, KIND_ONLY:  coriolis_acc = term;
            KIND_MIDDLE, KIND_LAST: coriolis_acc = fx_add(coriolis_acc, term);
            default:                coriolis_acc = '0;
        endcase
        if (kind == KIND_MIDDLE || kind == KIND_FIRST)
            return;
        pres_grad = fx_mul(fx_mul(fx_sub('0, widen(moist_coef)),
                                  fx_sub(widen(pressure_cell1), widen(pressure_cell0))),
                           widen(inv_dist));
        ke_grad = fx_mul(fx_sub(widen(ke_cell1), widen(ke_cell0)), widen(inv_dist));
        result = fx_add(pres_grad, fx_mul(widen(rho), fx_sub(coriolis_acc, ke_grad)));
        tendency_q.push_back(result[FIELD_WIDTH-1:0]);
        coriolis_acc = '0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coriolis_acc = '0;
            tendency_q.delete();
            fail_count = 0;
            pending = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                absorb_item();
            if (out_valid && !out_stall)
            begin
                if (tendency_q.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: tendency expected none, actual %h", $time, tendency);
                end
                else
                begin
                    expected_tend = tendency_q.pop_front();
                    if (tendency !== expected_tend)
                    begin
                        fail_count++;
                        $display("%0t: tendency expected %h, actual %h",
                                 $time, expected_tend, tendency);
                    end
                end
            end
            pending = tendency_q.size();
        end
    end

endmodule

// ===== tb/tb_edge_momentum_tendency.sv =====
`timescale 1ns / 1ps
// Testbench top for the edge momentum tendency block: stimulus, stalls and verdict.
module tb_edge_momentum_tendency;
    import etm_pkg::*;

    localparam field_t FMAX  = {1'b0, {(FIELD_WIDTH-1){1'b1}}};
    localparam field_t FMIN  = {1'b1, {(FIELD_WIDTH-1){1'b0}}};
    localparam field_t FZERO = '0;
    localparam field_t FONE  = field_t'(64'd1 << FRAC_BITS);
    localparam field_t FNEG1 = '1;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [2:0] kind;
    field_t     weight;
    field_t     u_nbr;
    field_t     pv_nbr;
    field_t     pv_self;
    field_t     pressure_cell0;
    field_t     pressure_cell1;
    field_t     ke_cell0;
    field_t     ke_cell1;
    field_t     moist_coef;
    field_t     inv_dist;
    field_t     rho;
    logic       out_valid;
    logic       out_stall;
    field_t     tendency;
    int         fail_count;
    int         pending;

    int         items_sent;
    bit         idle_on;

    edge_momentum_tendency uut (.*);

    etm_tendency_checker chk (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #8_000_000;
        $display("** edge_momentum_tendency: FAILED **");
        $finish;
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic field_t pick_val();
        int     r;
        field_t v;
        r = $urandom_range(0, 99);
        v = field_t'({$urandom, $urandom});
        if (r < 3)
            return FMAX;
        if (r < 6)
            return FMIN;
        if (r < 8)
            return FZERO;
        if (r < 10)
            return FONE;
        if (r < 12)
            return -FONE;
        if (r < 50)
            return field_t'($signed(v[20:0]));
        if (r < 75)
            return field_t'($signed(v[33:0]));
        return v;
    endfunction

    task automatic drive_item(input logic [2:0] k, input field_t w, input field_t un,
                              input field_t pn, input field_t ps, input field_t p0,
                              input field_t p1, input field_t k0, input field_t k1,
                              input field_t mc, input field_t idist, input field_t r);
        int gap;
        kind           <= k;
        weight         <= w;
        u_nbr          <= un;
        pv_nbr         <= pn;
        pv_self        <= ps;
        pressure_cell0 <= p0;
        pressure_cell1 <= p1;
        ke_cell0       <= k0;
        ke_cell1       <= k1;
        moist_coef     <= mc;
        inv_dist       <= idist;
        rho            <= r;
        in_valid       <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        if (k <= KIND_BOUNDARY)
            items_sent++;
        gap = idle_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_rand(input logic [2:0] k);
        drive_item(k, pick_val(), pick_val(), pick_val(), pick_val(), pick_val(), pick_val(),
                   pick_val(), pick_val(), pick_val(), pick_val(), pick_val());
    endtask

    task automatic drive_all(input logic [2:0] k, input field_t v);
        drive_item(k, v, v, v, v, v, v, v, v, v, v, v);
    endtask

    // hold the sender off until every expected tendency is back
    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        @(posedge clk);
    endtask

    // receiver stalls
    initial
    begin
        int n;
        out_stall = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            n = pick_gap();
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
                out_stall <= 1'b0;
            end
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(50, 300)) @(posedge clk);
            else
                repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    end

    initial
    begin
        int  r;
        int  n;
        int  next_phase;
        bit  paused;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        kind           = KIND_MIDDLE;
        weight         = '0;
        u_nbr          = '0;
        pv_nbr         = '0;
        pv_self        = '0;
        pressure_cell0 = '0;
        pressure_cell1 = '0;
        ke_cell0       = '0;
        ke_cell1       = '0;
        moist_coef     = '0;
        inv_dist       = '0;
        rho            = '0;
        items_sent     = 0;
        idle_on        = 1'b1;
        paused         = 1'b0;
        next_phase     = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed items
        send_rand(KIND_BOUNDARY);
        drive_all(KIND_NO_NBR, FMAX);
        drive_all(KIND_ONLY, FMAX);
        drive_all(KIND_ONLY, FMIN);
        drive_all(KIND_ONLY, FZERO);
        drive_all(KIND_FIRST, FONE);
        drive_item(KIND_MIDDLE, FONE, -FONE, FONE, FONE, FZERO, FONE, FZERO, FONE,
                   FONE, FONE, FONE);
        send_rand(KIND_MIDDLE);
        drive_item(KIND_LAST, FONE, FONE, FONE, FONE, -FONE, FONE, FONE, -FONE,
                   FONE, FONE, -FONE);
        // middle with no first before it
        drive_all(KIND_MIDDLE, FONE);
        drive_all(KIND_LAST, -FONE);
        send_rand(3'd6);
        send_rand(3'd7);
        // a second first restarts the sum
        drive_all(KIND_FIRST, FMAX);
        drive_all(KIND_FIRST, FONE);
        drive_all(KIND_LAST, FONE);
        // odd negative pv sum: half rounds down
        drive_item(KIND_ONLY, FONE, FONE, FZERO, field_t'(-3), FZERO, FZERO, FZERO, FZERO,
                   FZERO, FONE, FONE);
        drive_all(KIND_NO_NBR, FMIN);
        drive_all(KIND_FIRST, FMAX);
        drive_all(KIND_BOUNDARY, FMAX);
        drive_all(KIND_ONLY, FNEG1);
        drive_item(KIND_ONLY, FONE, FONE, FONE, FONE, FMIN, FMAX, FMAX, FMIN,
                   FMIN, FMIN, FMAX);

        // random runs, mostly well formed
        while (items_sent < 1420)
        begin
            if (items_sent >= next_phase)
            begin
                idle_on = ($urandom_range(0, 3) != 0);
                next_phase += 100;
            end
            if (!paused && items_sent >= 700)
            begin
                paused = 1'b1;
                wait_drained();
            end
            r = $urandom_range(0, 99);
            n = ($urandom_range(0, 99) < 70) ? $urandom_range(0, 2) : $urandom_range(3, 8);
            if (r < 55)
            begin
                send_rand(KIND_FIRST);
                repeat (n) send_rand(KIND_MIDDLE);
                send_rand(KIND_LAST);
            end
            else if (r < 65)
                send_rand(KIND_ONLY);
            else if (r < 72)
                send_rand(KIND_NO_NBR);
            else if (r < 78)
                send_rand(KIND_BOUNDARY);
            else if (r < 86)
            begin
                repeat (n + 1) send_rand(KIND_MIDDLE);
                send_rand(KIND_LAST);
            end
            else if (r < 92)
            begin
                send_rand(KIND_FIRST);
                send_rand(KIND_MIDDLE);
                send_rand(KIND_FIRST);
                send_rand(KIND_LAST);
            end
            else if (r < 95)
                send_rand(KIND_LAST);
            else if (r < 97)
                send_rand(KIND_MIDDLE);
            else
                send_rand(3'($urandom_range(6, 7)));
        end

        wait_drained();
        repeat (60) @(posedge clk);
        if (fail_count == 0)
            $display("** edge_momentum_tendency: PASSED **");
        else
            $display("** edge_momentum_tendency: FAILED **");
        $finish;
    end

endmodule
